// ----- rtl/core/rule_accumulator_vm_step_unit_defines.svh -----
// Assertion macros shared by the rule accumulator RTL.
`ifndef RULE_ACCUMULATOR_VM_STEP_UNIT_DEFINES_SVH
`define RULE_ACCUMULATOR_VM_STEP_UNIT_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define RAV_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rule accumulator check failed");

// Check that cons holds in the cycle after ante.
`define RAV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rule accumulator check failed");

`endif

// ----- rtl/core/rav_pkg.sv -----
// Types and constants of the rule accumulator step unit.
`timescale 1ns / 1ps
`default_nettype none
package rav_pkg;

    localparam int DATA_W  = 32;
    localparam int INDEX_W = 4;
    localparam int STEP_W  = 6;
    localparam int MASK_W  = 16;

    localparam logic [DATA_W-1:0] LOW24_MASK = 32'h00FF_FFFF;

    // Item kinds
    localparam logic [1:0] ACT_EXEC   = 2'd0;
    localparam logic [1:0] ACT_UPDATE = 2'd1;
    localparam logic [1:0] ACT_TAKE   = 2'd2;
    localparam logic [1:0] ACT_ACK    = 2'd3;

    // Instruction codes
    localparam logic [3:0] OP_CLR  = 4'd0;
    localparam logic [3:0] OP_LDI  = 4'd1;
    localparam logic [3:0] OP_LD24 = 4'd2;
    localparam logic [3:0] OP_LD   = 4'd3;
    localparam logic [3:0] OP_ST24 = 4'd4;
    localparam logic [3:0] OP_ST   = 4'd5;
    localparam logic [3:0] OP_LT   = 4'd6;
    localparam logic [3:0] OP_GT   = 4'd7;
    localparam logic [3:0] OP_EQI  = 4'd8;
    localparam logic [3:0] OP_EQ   = 4'd9;
    localparam logic [3:0] OP_BZ   = 4'd10;
    localparam logic [3:0] OP_BNZ  = 4'd11;
    localparam logic [3:0] OP_DLY  = 4'd12;

    typedef struct packed {
        logic [1:0]         action;
        logic [3:0]         opcode;
        logic [INDEX_W-1:0] io_index;
        logic [DATA_W-1:0]  immediate;
        logic               update_low24;
        logic [STEP_W-1:0]  next_step;
        logic               next_end;
        logic [STEP_W-1:0]  branch_step;
        logic               branch_end;
    } t_cmd_item;

    typedef struct packed {
        logic [DATA_W-1:0]  acc_value;
        logic [STEP_W-1:0]  follow_step;
        logic               follow_end;
        logic               event_found;
        logic [INDEX_W-1:0] event_index;
        logic [DATA_W-1:0]  entry_value;
        logic [MASK_W-1:0]  writeback_mask;
    } t_res_item;

endpackage
`default_nettype wire

// ----- rtl/core/rav_stream_if.sv -----
// Valid/ready stream interface carrying one payload beat.
`timescale 1ns / 1ps
`default_nettype none
interface rav_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/rule_accumulator_vm_step_unit.sv -----
// Rule accumulator machine: executes one instruction or entry action per beat.
//
// Usage:
//   i_cmd carries command beats (execute, entry update, take event, acknowledge
//   write-back); o_res carries one result beat per command, in order.
//   A command is captured into an input register, evaluated by single-level
//   logic against the accumulator, operand and entry table, and the result is
//   written into the output register in the same cycle the state is updated.
//   An accepted command moves from the input register to the output register
//   when it is free or draining; o_res.ready high then takes the result beat.
//   Throughput: 1 beat per cycle while o_res.ready holds; the input and output
//   registers advance together, so a new command is taken while a result waits.
//   When the receiver stalls, the result holds in the output register and at
//   most one more command waits in the input register; i_cmd.ready then drops.
//   Reset (synchronous, active low) clears the accumulator, the operand, all
//   entry values, event marks and write-back marks, and empties both registers.
//   IO_ENTRIES sets the entry table depth; entries past 16 cannot be addressed.
`timescale 1ns / 1ps
`default_nettype none
`include "rule_accumulator_vm_step_unit_defines.svh"
module rule_accumulator_vm_step_unit #(
    parameter int IO_ENTRIES = 16
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    rav_stream_if.sink   i_cmd,
    rav_stream_if.source o_res
);
    import rav_pkg::*;

    localparam int ENTRY_DEPTH = (IO_ENTRIES < (1 << INDEX_W)) ? IO_ENTRIES : (1 << INDEX_W);
    localparam int ENTRY_IW    = (ENTRY_DEPTH > 1) ? $clog2(ENTRY_DEPTH) : 1;

    // Pipeline registers
    logic      r_cmd_vld;
    t_cmd_item r_cmd;
    logic      r_res_vld;
    t_res_item r_res;

    // Machine state
    logic [DATA_W-1:0]      r_acc;
    logic [DATA_W-1:0]      r_opnd;
    logic [DATA_W-1:0]      r_entry [ENTRY_DEPTH];
    logic [ENTRY_DEPTH-1:0] r_event;
    logic [ENTRY_DEPTH-1:0] r_wb;

    logic [DATA_W-1:0]      n_acc;
    logic [DATA_W-1:0]      n_opnd;
    logic [ENTRY_DEPTH-1:0] n_event;
    logic [ENTRY_DEPTH-1:0] n_wb;
    t_res_item              n_res;

    logic                   advance;
    logic                   idx_ok;
    logic [ENTRY_IW-1:0]    eidx;
    logic [DATA_W-1:0]      rd_val;
    logic                   wr_en;
    logic [DATA_W-1:0]      wr_val;
    logic                   take;
    logic                   found;
    logic [ENTRY_IW-1:0]    ev_sel;
    logic [INDEX_W-1:0]     ev_idx;
    logic                   upd_change;
    logic [DATA_W-1:0]      upd_val;

    // Move a beat on when the output register is free or being drained
    assign advance     = r_cmd_vld && (!r_res_vld || o_res.ready);
    assign i_cmd.ready = !r_cmd_vld || advance;
    assign o_res.valid = r_res_vld;
    assign o_res.data  = r_res;

    // Address the entry table
    assign idx_ok = 32'(r_cmd.io_index) < IO_ENTRIES;
    assign eidx   = r_cmd.io_index[ENTRY_IW-1:0];
    assign rd_val = idx_ok ? r_entry[eidx] : '0;

    // Find the lowest pending event
    always_comb begin
        found  = 1'b0;
        ev_sel = '0;
        for (int i = ENTRY_DEPTH - 1; i >= 0; i--) begin
            if (r_event[i]) begin
                found  = 1'b1;
                ev_sel = ENTRY_IW'(i);
            end
        end
        ev_idx = INDEX_W'(ev_sel);
    end

    // Compare an external update against the stored value
    always_comb begin
        if (r_cmd.update_low24) begin
            upd_change = (rd_val & LOW24_MASK) != (r_cmd.immediate & LOW24_MASK);
            upd_val    = (rd_val & ~LOW24_MASK) | (r_cmd.immediate & LOW24_MASK);
        end else begin
            upd_change = rd_val != r_cmd.immediate;
            upd_val    = r_cmd.immediate;
        end
    end

    // Evaluate the beat held in the input register
    always_comb begin
        n_acc   = r_acc;
        n_opnd  = r_opnd;
        n_event = r_event;
        n_wb    = r_wb;
        wr_en   = 1'b0;
        wr_val  = r_acc;
        take    = 1'b0;
        n_res   = '0;
        n_res.follow_end = 1'b1;

        case (r_cmd.action)
            ACT_EXEC: begin
                case (r_cmd.opcode)
                    OP_CLR: begin
                        n_acc = '0;
                    end
                    OP_LDI: begin
                        n_opnd = r_cmd.immediate;
                        n_acc  = r_cmd.immediate;
                    end
                    OP_LD24: begin
                        n_opnd = rd_val & LOW24_MASK;
                        n_acc  = rd_val & LOW24_MASK;
                    end
                    OP_LD: begin
                        n_opnd = rd_val;
                        n_acc  = rd_val;
                    end
                    OP_ST24: begin
                        wr_en  = idx_ok;
                        wr_val = (rd_val & ~LOW24_MASK) | (r_acc & LOW24_MASK);
                    end
                    OP_ST: begin
                        wr_en  = idx_ok;
                        wr_val = r_acc;
                    end
                    OP_LT: begin
                        n_opnd = rd_val;
                        n_acc  = DATA_W'(rd_val < r_acc);
                    end
                    OP_GT: begin
                        n_opnd = rd_val;
                        n_acc  = DATA_W'(rd_val > r_acc);
                    end
                    OP_EQI: begin
                        n_opnd = r_cmd.immediate;
                        n_acc  = DATA_W'(r_cmd.immediate == r_acc);
                    end
                    OP_EQ: begin
                        n_opnd = rd_val;
                        n_acc  = DATA_W'(rd_val == r_acc);
                    end
                    OP_BZ: begin
                        take = r_acc == '0;
                    end
                    OP_BNZ: begin
                        take = r_acc != '0;
                    end
                    OP_DLY: begin
                        n_opnd = rd_val;
                    end
                    default: begin
                    end
                endcase
                if (wr_en) begin
                    n_wb[eidx] = 1'b1;
                end
                n_res.follow_step = take ? r_cmd.branch_step : r_cmd.next_step;
                n_res.follow_end  = take ? r_cmd.branch_end : r_cmd.next_end;
            end
            ACT_UPDATE: begin
                if (idx_ok && upd_change) begin
                    wr_en         = 1'b1;
                    wr_val        = upd_val;
                    n_event[eidx] = 1'b1;
                end
            end
            ACT_TAKE: begin
                if (found) begin
                    n_event[ev_sel]   = 1'b0;
                    n_acc             = '0;
                    n_opnd            = '0;
                    n_res.event_found = 1'b1;
                    n_res.event_index = ev_idx;
                end
            end
            ACT_ACK: begin
                if (idx_ok) begin
                    n_wb[eidx] = 1'b0;
                end
            end
            default: begin
            end
        endcase

        n_res.acc_value   = n_acc;
        n_res.entry_value = idx_ok ? (wr_en ? wr_val : rd_val) : '0;
        for (int i = 0; i < ENTRY_DEPTH; i++) begin
            n_res.writeback_mask[i] = n_wb[i];
        end
    end

    // Hold control state and machine state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_vld <= 1'b0;
            r_res_vld <= 1'b0;
            r_acc     <= '0;
            r_opnd    <= '0;
            r_event   <= '0;
            r_wb      <= '0;
            for (int i = 0; i < ENTRY_DEPTH; i++) begin
                r_entry[i] <= '0;
            end
        end else begin
            if (i_cmd.ready) begin
                r_cmd_vld <= i_cmd.valid;
            end
            if (advance) begin
                r_res_vld <= 1'b1;
                r_acc     <= n_acc;
                r_opnd    <= n_opnd;
                r_event   <= n_event;
                r_wb      <= n_wb;
                if (wr_en) begin
                    r_entry[eidx] <= wr_val;
                end
            end else if (o_res.ready) begin
                r_res_vld <= 1'b0;
            end
        end
    end

    // Capture payload beats
    always_ff @(posedge i_clk) begin
        if (i_cmd.ready && i_cmd.valid) begin
            r_cmd <= i_cmd.data;
        end
        if (advance) begin
            r_res <= n_res;
        end
    end

    // Taking an event clears both registers
    `RAV_ASSERT_NOW(a_event_clears_acc, i_clk, i_rst_n,
        o_res.valid && o_res.data.event_found, o_res.data.acc_value == '0)
    // Non-execute beats carry no successor
    `RAV_ASSERT_NEXT(a_no_follow, i_clk, i_rst_n,
        advance && (r_cmd.action != ACT_EXEC),
        o_res.data.follow_end && (o_res.data.follow_step == '0))
    // Reported mask tracks the write-back marks
    `RAV_ASSERT_NEXT(a_wb_mask, i_clk, i_rst_n,
        advance, o_res.data.writeback_mask[ENTRY_DEPTH-1:0] == r_wb)
    // A taken event mark is gone afterwards
    `RAV_ASSERT_NEXT(a_event_cleared, i_clk, i_rst_n,
        advance && (r_cmd.action == ACT_TAKE) && found, !r_event[$past(ev_sel)])

endmodule
`default_nettype wire

// ----- tb/rule_accumulator_vm_step_unit_tb.sv -----
// Self-checking testbench for the rule accumulator step unit.
`timescale 1ns / 1ps
module rule_accumulator_vm_step_unit_tb;
    import rav_pkg::*;

    localparam int ENTRY_COUNT    = 16;
    localparam int TARGET_BEATS   = 1800;
    localparam int QUIET_FROM     = 1500;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 2000;

    // Scoreboard: shadow machine state plus the queue of results still due
    class rule_scoreboard;
        logic [DATA_W-1:0] acc;
        logic [DATA_W-1:0] operand;
        logic [DATA_W-1:0] entries [ENTRY_COUNT];
        logic [MASK_W-1:0] event_marks;
        logic [MASK_W-1:0] wb_marks;
        t_res_item         results_due [$];
        int errors;
        int checked;
        int n_exec;
        int n_update;
        int n_take;
        int n_ack;
        int n_found;
        int n_branch_taken;

        function new();
            acc         = '0;
            operand     = '0;
            event_marks = '0;
            wb_marks    = '0;
            foreach (entries[i]) entries[i] = '0;
            errors = 0;
            checked = 0;
            n_exec = 0;
            n_update = 0;
            n_take = 0;
            n_ack = 0;
            n_found = 0;
            n_branch_taken = 0;
        endfunction

        // Advance the shadow state by one command and build its result
        function t_res_item execute_rule_item(t_cmd_item c);
            t_res_item         r;
            logic              taken;
            logic              found;
            logic [DATA_W-1:0] cur;
            logic [DATA_W-1:0] merged;
            r = '0;
            r.follow_end = 1'b1;
            taken = 1'b0;
            found = 1'b0;
            cur = entries[c.io_index];
            case (c.action)
                ACT_EXEC: begin
                    n_exec++;
                    case (c.opcode)
                        OP_CLR:  acc = '0;
                        OP_LDI:  begin operand = c.immediate; acc = operand; end
                        OP_LD24: begin operand = cur & LOW24_MASK; acc = operand; end
                        OP_LD:   begin operand = cur; acc = operand; end
                        OP_ST24: begin
                            entries[c.io_index]  = (cur & ~LOW24_MASK) | (acc & LOW24_MASK);
                            wb_marks[c.io_index] = 1'b1;
                        end
                        OP_ST: begin
                            entries[c.io_index]  = acc;
                            wb_marks[c.io_index] = 1'b1;
                        end
                        OP_LT:   begin operand = cur; acc = {31'd0, operand < acc}; end
                        OP_GT:   begin operand = cur; acc = {31'd0, operand > acc}; end
                        OP_EQI:  begin operand = c.immediate; acc = {31'd0, operand == acc}; end
                        OP_EQ:   begin operand = cur; acc = {31'd0, operand == acc}; end
                        OP_BZ:   taken = (acc == '0);
                        OP_BNZ:  taken = (acc != '0);
                        OP_DLY:  operand = cur;
                        default: ;
                    endcase
                    if (taken) n_branch_taken++;
                    r.follow_step = taken ? c.branch_step : c.next_step;
                    r.follow_end  = taken ? c.branch_end : c.next_end;
                end
                ACT_UPDATE: begin
                    n_update++;
                    if (c.update_low24) begin
                        merged = (cur & ~LOW24_MASK) | (c.immediate & LOW24_MASK);
                    end else begin
                        merged = c.immediate;
                    end
                    if (merged != cur) begin
                        entries[c.io_index]     = merged;
                        event_marks[c.io_index] = 1'b1;
                    end
                end
                ACT_TAKE: begin
                    n_take++;
                    // take the lowest marked entry only
                    for (int i = 0; i < ENTRY_COUNT; i++) begin
                        if (!found && event_marks[i]) begin
                            found          = 1'b1;
                            event_marks[i] = 1'b0;
                            r.event_index  = i[INDEX_W-1:0];
                            acc            = '0;
                            operand        = '0;
                        end
                    end
                    r.event_found = found;
                    if (found) n_found++;
                end
                default: begin
                    n_ack++;
                    wb_marks[c.io_index] = 1'b0;
                end
            endcase
            r.acc_value      = acc;
            r.entry_value    = entries[c.io_index];
            r.writeback_mask = wb_marks;
            return r;
        endfunction

        function void note_command(t_cmd_item c);
            results_due.push_back(execute_rule_item(c));
        endfunction

        function void check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
            if (want !== got) begin
                $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_res_item got);
            t_res_item want;
            if (results_due.size() == 0) begin
                $error("result beat arrived with no command outstanding");
                errors++;
                return;
            end
            want = results_due.pop_front();
            checked++;
            check_field("acc_value", want.acc_value, got.acc_value);
            check_field("follow_step", DATA_W'(want.follow_step), DATA_W'(got.follow_step));
            check_field("follow_end", DATA_W'(want.follow_end), DATA_W'(got.follow_end));
            check_field("event_found", DATA_W'(want.event_found), DATA_W'(got.event_found));
            check_field("event_index", DATA_W'(want.event_index), DATA_W'(got.event_index));
            check_field("entry_value", want.entry_value, got.entry_value);
            check_field("writeback_mask", DATA_W'(want.writeback_mask),
                        DATA_W'(got.writeback_mask));
        endfunction

        function int pending();
            return results_due.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    rav_stream_if #(.t_payload(t_cmd_item)) cmd_if ();
    rav_stream_if #(.t_payload(t_res_item)) res_if ();

    rule_scoreboard book = new();

    logic idle_on        = 1'b1;
    logic long_hold_req  = 1'b0;
    int   beats_sent     = 0;
    int   stall_cycles   = 0;

    rule_accumulator_vm_step_unit #(
        .IO_ENTRIES(ENTRY_COUNT)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if.sink),
        .o_res   (res_if.source)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Observe both channels: note accepted commands, check accepted results
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if ((cmd_if.valid && cmd_if.ready) === 1'b1) book.note_command(cmd_if.data);
            if ((res_if.valid && res_if.ready) === 1'b1) book.check_result(res_if.data);
        end
    end

    // Watchdog: end the run when no beat moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && (((cmd_if.valid && cmd_if.ready) === 1'b1) ||
                                 ((res_if.valid && res_if.ready) === 1'b1))) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    // Result receiver: random stall bursts and one long hold-off on request
    initial begin
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                res_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end else begin
                res_if.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Mix of edge values and small values so compares and updates hit
    function automatic logic [DATA_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 32'd1;
            2:       return '1;
            3:       return LOW24_MASK;
            4:       return ~LOW24_MASK;
            5:       return $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_cmd_item random_cmd();
        t_cmd_item   c;
        int unsigned pick;
        pick = $urandom_range(0, 9);
        c.action       = (pick < 6) ? ACT_EXEC : (pick < 8) ? ACT_UPDATE :
                         (pick == 8) ? ACT_TAKE : ACT_ACK;
        c.opcode       = 4'($urandom_range(0, 15));
        c.io_index     = INDEX_W'($urandom_range(0, 15));
        c.immediate    = pick_word();
        c.update_low24 = 1'($urandom_range(0, 1));
        c.next_step    = STEP_W'($urandom_range(0, 63));
        c.next_end     = 1'($urandom_range(0, 1));
        c.branch_step  = STEP_W'($urandom_range(0, 63));
        c.branch_end   = 1'($urandom_range(0, 1));
        return c;
    endfunction

    function automatic t_cmd_item exec_item(logic [3:0] op, logic [INDEX_W-1:0] idx,
                                            logic [DATA_W-1:0] imm);
        t_cmd_item c;
        c = random_cmd();
        c.action    = ACT_EXEC;
        c.opcode    = op;
        c.io_index  = idx;
        c.immediate = imm;
        return c;
    endfunction

    function automatic t_cmd_item entry_item(logic [1:0] act, logic [INDEX_W-1:0] idx,
                                             logic [DATA_W-1:0] imm, logic low24);
        t_cmd_item c;
        c = random_cmd();
        c.action       = act;
        c.io_index     = idx;
        c.immediate    = imm;
        c.update_low24 = low24;
        return c;
    endfunction

    // Offer one command beat and hold it until accepted
    task automatic send_command(input t_cmd_item c);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            cmd_if.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.data  <= c;
        @(posedge i_clk);
        while (cmd_if.ready !== 1'b1) @(posedge i_clk);
        beats_sent++;
    endtask

    // Typical rule: updates raise events, take one, test it, branch, write back
    task automatic send_event_rule();
        t_cmd_item         c;
        logic [INDEX_W-1:0] idx;
        idx = INDEX_W'($urandom_range(0, 15));
        send_command(entry_item(ACT_UPDATE, idx, pick_word(), 1'($urandom_range(0, 1))));
        repeat ($urandom_range(0, 2)) begin
            send_command(entry_item(ACT_UPDATE, INDEX_W'($urandom_range(0, 15)), pick_word(),
                                    1'($urandom_range(0, 1))));
        end
        send_command(entry_item(ACT_TAKE, INDEX_W'($urandom_range(0, 15)), pick_word(), 1'b0));
        send_command(exec_item($urandom_range(0, 1) ? OP_LD : OP_LD24, idx, pick_word()));
        case ($urandom_range(0, 3))
            0:       c = exec_item(OP_LT, INDEX_W'($urandom_range(0, 15)), pick_word());
            1:       c = exec_item(OP_GT, INDEX_W'($urandom_range(0, 15)), pick_word());
            2:       c = exec_item(OP_EQI, idx, pick_word());
            default: c = exec_item(OP_EQ, INDEX_W'($urandom_range(0, 15)), pick_word());
        endcase
        send_command(c);
        send_command(exec_item($urandom_range(0, 1) ? OP_BZ : OP_BNZ, idx, pick_word()));
        if ($urandom_range(0, 2) != 0) begin
            send_command(exec_item($urandom_range(0, 1) ? OP_ST : OP_ST24, idx, pick_word()));
        end
        if ($urandom_range(0, 3) == 0) send_command(exec_item(OP_DLY, idx, pick_word()));
        if ($urandom_range(0, 1) != 0) begin
            send_command(entry_item(ACT_ACK, idx, pick_word(), 1'b0));
        end
    endtask

    initial begin
        t_cmd_item c;
        logic      hold_done;
        hold_done = 1'b0;
        i_rst_n      <= 1'b0;
        cmd_if.valid <= 1'b0;
        cmd_if.data  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every opcode, field extremes, update and event corner cases
        c = exec_item(OP_LDI, 4'd0, '1);
        c.next_step = 6'd63;
        c.next_end  = 1'b0;
        send_command(c);
        send_command(exec_item(OP_ST, 4'd15, '0));
        c = exec_item(OP_CLR, 4'd0, '0);
        c.next_step = 6'd0;
        c.next_end  = 1'b1;
        send_command(c);
        send_command(exec_item(OP_ST24, 4'd0, '0));
        send_command(exec_item(OP_LD24, 4'd15, '0));
        send_command(exec_item(OP_ST24, 4'd3, '0));
        send_command(exec_item(OP_LD, 4'd15, '0));
        send_command(exec_item(OP_LT, 4'd3, '0));
        send_command(exec_item(OP_GT, 4'd15, '0));
        send_command(exec_item(OP_EQI, 4'd0, 32'd1));
        send_command(exec_item(OP_EQ, 4'd0, '0));
        c = exec_item(OP_BZ, 4'd0, '0);
        c.branch_step = 6'd63;
        c.branch_end  = 1'b0;
        send_command(c);
        send_command(exec_item(OP_BNZ, 4'd0, '0));
        send_command(exec_item(OP_DLY, 4'd15, '0));
        send_command(exec_item(4'd13, 4'd7, '1));
        send_command(exec_item(4'd15, 4'd8, '1));
        // value change raises an event, same value does not
        send_command(entry_item(ACT_UPDATE, 4'd5, 32'hA5A5_A5A5, 1'b0));
        send_command(entry_item(ACT_UPDATE, 4'd5, 32'hA5A5_A5A5, 1'b0));
        // low-24 update keeps the top byte and ignores a top-byte-only change
        send_command(entry_item(ACT_UPDATE, 4'd2, 32'h1234_5678, 1'b1));
        send_command(entry_item(ACT_UPDATE, 4'd2, 32'hFF34_5678, 1'b1));
        send_command(entry_item(ACT_UPDATE, 4'd15, '0, 1'b1));
        send_command(entry_item(ACT_ACK, 4'd15, '0, 1'b0));
        send_command(entry_item(ACT_ACK, 4'd3, '0, 1'b0));
        // drain all marks, then take with nothing pending
        repeat (4) send_command(entry_item(ACT_TAKE, 4'd0, '0, 1'b0));

        // Random: mostly well-formed rules, the rest loose commands
        while (beats_sent < TARGET_BEATS) begin
            if (!hold_done && beats_sent > 600) begin
                hold_done     = 1'b1;
                long_hold_req = 1'b1;
            end
            idle_on = !((beats_sent >= 900 && beats_sent < 1100) || beats_sent >= QUIET_FROM);
            if ($urandom_range(0, 3) != 0) begin
                send_event_rule();
            end else begin
                send_command(random_cmd());
            end
        end
        cmd_if.valid <= 1'b0;

        // Drain outstanding results, then allow the pipeline to settle
        while (book.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("summary: %0d commands (%0d execute, %0d update, %0d take, %0d ack)",
                 beats_sent, book.n_exec, book.n_update, book.n_take, book.n_ack);
        $display("summary: %0d results checked, %0d events taken, %0d branches taken",
                 book.checked, book.n_found, book.n_branch_taken);
        if (book.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
